// File: src/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants of the bicubic upscale sampler
// Holds the controller/datapath command and status groups, the register
// indexes, the output saturation limits and the cubic kernel weight function.
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_SCALE  = 2'd2;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic signed [19:0] OUT_MIN = -20'sd2048;
	localparam logic signed [19:0] OUT_MAX = 20'sd6143;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RUN    = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	typedef struct packed {
		logic capture;
		logic store;
		logic issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic req_bad;
		logic last_tap;
		logic pipe_busy;
		logic out_free;
	} sts_t;

	// keys weight times 1024 for a distance of m/8 pixels
	function automatic logic signed [11:0] kernel_w(input logic [4:0] m);
		int mi;
		int v;
		mi = int'(m);
		if (mi < 8) begin
			v = 3 * mi * mi * mi - 40 * mi * mi + 1024;
		end else if (mi < 16) begin
			v = -mi * mi * mi + 40 * mi * mi - 512 * mi + 2048;
		end else begin
			v = 0;
		end
		return 12'(v);
	endfunction

	// distance in eighths from the sample position to tap k (k = 0 is offset -1)
	function automatic logic [4:0] tap_dist(input logic [1:0] k, input logic [2:0] f);
		logic [4:0] d;
		case (k)
			2'd0: d = 5'd8 + {2'b00, f};
			2'd1: d = {2'b00, f};
			2'd2: d = 5'd8 - {2'b00, f};
			default: d = 5'd16 - {2'b00, f};
		endcase
		return d;
	endfunction

endpackage

// File: src/bcs_if.sv
// ----------------------------------------------------------------------------
// bcs_if: channel interfaces of the bicubic upscale sampler
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcs_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [1:0] channel;
	logic [7:0] col;
	logic [7:0] row;
	logic [7:0] pixel_value;

	modport source (output valid, action, channel, col, row, pixel_value, input ready);
	modport sink (input valid, action, channel, col, row, pixel_value, output ready);
endinterface

interface bcs_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] sample_value;
	logic               bad_request;

	modport source (output valid, sample_value, bad_request, input ready);
	modport sink (input valid, sample_value, bad_request, output ready);
endinterface

interface bcs_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [6:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/bcs_ctrl.sv
// ----------------------------------------------------------------------------
// bcs_ctrl: sequencing controller
// Accepts request transactions, steps the datapath through the sixteen tap
// reads, waits for the pipeline to drain and hands the result to the output.
// ----------------------------------------------------------------------------
module bcs_ctrl import bcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.action == ACT_SAMPLE) begin
						cmd.capture = 1'b1;
						state_nxt   = sts.req_bad ? ST_FINISH : ST_RUN;
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.last_tap) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: src/bcs_datapath.sv
// ----------------------------------------------------------------------------
// bcs_datapath: image store, tap address generation and weighted accumulation
// Holds the configuration registers, the single-ported pixel memory, the
// weight/product pipeline, the accumulator and the output register.
// ----------------------------------------------------------------------------
module bcs_datapath import bcs_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int CHANNELS   = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               req_action,
	input  logic [1:0]         req_channel,
	input  logic [7:0]         req_col,
	input  logic [7:0]         req_row,
	input  logic [7:0]         req_pixel_value,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output logic signed [13:0] rsp_sample_value,
	output logic               rsp_bad_request
);

	localparam int PLANE = MAX_HEIGHT * MAX_WIDTH;
	localparam int DEPTH = CHANNELS * PLANE;
	localparam int AW    = $clog2(DEPTH);

	logic [6:0] width_q;
	logic [6:0] height_q;
	logic       scale_q;
	logic [6:0] ew;
	logic [6:0] eh;
	logic [8:0] col_lim;
	logic [8:0] row_lim;
	logic       wr_ok;
	logic       req_bad;

	logic signed [9:0] nx;
	logic signed [9:0] ny;
	logic signed [9:0] bx_full;
	logic signed [9:0] by_full;

	logic [1:0]        ch_q;
	logic signed [7:0] bx_q;
	logic signed [7:0] by_q;
	logic [2:0]        fx_q;
	logic [2:0]        fy_q;
	logic              bad_q;
	logic [3:0]        tap_q;

	logic [7:0]          mem_q [DEPTH];
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	logic [6:0]          cx;
	logic [6:0]          cy;
	logic signed [11:0]  wx;
	logic signed [11:0]  wy;
	logic [7:0]          rd_s1;
	logic signed [21:0]  w_s1;
	logic                v_s1;
	logic signed [29:0]  prod_s2;
	logic                v_s2;
	logic signed [35:0]  acc_q;
	logic signed [35:0]  rnd;
	logic signed [19:0]  q;
	logic signed [13:0]  sat;
	logic                out_valid_q;
	logic signed [13:0]  out_value_q;
	logic                out_bad_q;

	function automatic logic [6:0] clamp_coord(input logic signed [7:0] base,
			input logic [1:0] k, input logic [6:0] lim);
		logic [2:0] j;
		logic [8:0] c;
		logic [6:0] hi;
		j  = {1'b0, k} - 3'd1;
		c  = {base[7], base} + {{6{j[2]}}, j};
		hi = lim - 7'd1;
		if (c[8]) begin
			return 7'd0;
		end else if (c[7:0] > {1'b0, hi}) begin
			return hi;
		end else begin
			return c[6:0];
		end
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			scale_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_SCALE:  scale_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ew = (int'(width_q) > MAX_WIDTH) ? 7'(MAX_WIDTH) : width_q;
	assign eh = (int'(height_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : height_q;

	assign col_lim = scale_q ? {ew, 2'b00} : {1'b0, ew, 1'b0};
	assign row_lim = scale_q ? {eh, 2'b00} : {1'b0, eh, 1'b0};

	assign wr_ok = (int'(req_channel) < CHANNELS) && (req_col < {1'b0, ew})
		&& (req_row < {1'b0, eh});
	assign req_bad = (int'(req_channel) >= CHANNELS) || ({1'b0, req_col} >= col_lim)
		|| ({1'b0, req_row} >= row_lim);

	// back-projected source position
	assign nx = $signed({1'b0, req_col, 1'b1}) - (scale_q ? 10'sd4 : 10'sd2);
	assign ny = $signed({1'b0, req_row, 1'b1}) - (scale_q ? 10'sd4 : 10'sd2);
	assign bx_full = scale_q ? (nx >>> 3) : (nx >>> 2);
	assign by_full = scale_q ? (ny >>> 3) : (ny >>> 2);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q  <= req_channel;
			bx_q  <= bx_full[7:0];
			by_q  <= by_full[7:0];
			fx_q  <= scale_q ? nx[2:0] : {nx[1:0], 1'b0};
			fy_q  <= scale_q ? ny[2:0] : {ny[1:0], 1'b0};
			bad_q <= req_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (cmd.capture) begin
			tap_q <= '0;
		end else if (cmd.issue) begin
			tap_q <= tap_q + 4'd1;
		end
	end

	assign cx = clamp_coord(bx_q, tap_q[1:0], ew);
	assign cy = clamp_coord(by_q, tap_q[3:2], eh);
	assign wx = kernel_w(tap_dist(tap_q[1:0], fx_q));
	assign wy = kernel_w(tap_dist(tap_q[3:2], fy_q));

	assign wr_addr = AW'(int'(req_channel) * PLANE + int'(req_row) * MAX_WIDTH
		+ int'(req_col));
	assign rd_addr = AW'(int'(ch_q) * PLANE + int'(cy) * MAX_WIDTH + int'(cx));

	// pixel store and tap pipeline
	always_ff @(posedge clk) begin
		if (cmd.store && wr_ok) begin
			mem_q[wr_addr] <= req_pixel_value;
		end
		if (cmd.issue) begin
			rd_s1 <= mem_q[rd_addr];
			w_s1  <= 22'(24'(wx) * 24'(wy));
		end
		if (v_s1) begin
			prod_s2 <= 30'(32'(w_s1) * 32'($signed({1'b0, rd_s1})));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + 36'(prod_s2);
		end
	end

	// round half up to 1/16 steps and saturate
	assign rnd = acc_q + 36'sd32768;
	assign q   = rnd[35:16];

	always_comb begin
		if (q < OUT_MIN) begin
			sat = 14'(OUT_MIN);
		end else if (q > OUT_MAX) begin
			sat = 14'(OUT_MAX);
		end else begin
			sat = 14'(q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q <= bad_q ? 14'sd0 : sat;
			out_bad_q   <= bad_q;
		end
	end

	assign rsp_valid        = out_valid_q;
	assign rsp_sample_value = out_value_q;
	assign rsp_bad_request  = out_bad_q;

	assign sts.action    = req_action;
	assign sts.req_bad   = req_bad;
	assign sts.last_tap  = &tap_q;
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_free  = !out_valid_q || rsp_ready;

endmodule

// File: src/bicubic_upscale_sampler.sv
// operation: a write is performed when its transaction is accepted, one per
// cycle while idle; a sample makes 16 tap reads of the single-port pixel
// memory, drains the pipeline, then rounds and loads the output register,
// and no request is taken until it is through; out-of-range ones skip reads
// reset: arst_n clears control state and loads width 64, height 64, scale x2;
// the pixel memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// bicubic_upscale_sampler: bicubic x2/x4 upscaler, keys kernel a = -0.5
// Stores planar 8-bit source pixels and returns one interpolated output pixel
// per sample transaction from an edge-clamped 4x4 source neighbourhood.
// ----------------------------------------------------------------------------
module bicubic_upscale_sampler import bcs_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int CHANNELS   = 3
) (
	input logic           clk,
	input logic           arst_n,
	bcs_req_if.sink       req,
	bcs_rsp_if.source     rsp,
	bcs_cfg_if.sink       cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	bcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bcs_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CHANNELS   (CHANNELS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.req_action       (req.action),
		.req_channel      (req.channel),
		.req_col          (req.col),
		.req_row          (req.row),
		.req_pixel_value  (req.pixel_value),
		.cfg_valid        (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_sample_value (rsp.sample_value),
		.rsp_bad_request  (rsp.bad_request)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.store, cmd.issue, cmd.load_out}))
		else $error("more than one datapath command at once");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue || sts.pipe_busy) |-> !req.ready)
		else $error("request ready while taps are in flight");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp.valid)
		else $error("loaded result not presented");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp.valid || rsp.ready))
		else $error("result overwritten before transaction");

endmodule
